// ----- rtl/core/kpc_pkg.sv -----
// kpc_pkg: shared constants and types for the key position calibrator.
// No dependencies.
package kpc_pkg;

	localparam int RING_DEPTH   = 32;
	localparam int RING_AW      = $clog2(RING_DEPTH);
	localparam int FILL_W       = $clog2(RING_DEPTH + 1);
	localparam int PRESS_WINDOW = 8;
	localparam int SAMPLE_BITS  = 12;
	localparam int SUM_W        = SAMPLE_BITS + FILL_W;
	localparam int POS_W        = 14;
	localparam int DIV_NW       = SAMPLE_BITS + 12;
	localparam int DIV_DW       = (SAMPLE_BITS > FILL_W) ? SAMPLE_BITS : FILL_W;
	localparam int DIV_CW       = $clog2(DIV_NW);
	localparam int POS_LOW_MAG  = 2048;
	localparam int POS_HIGH     = 4915;
	localparam int MIN_RANGE_RST = 64;

	typedef enum logic [2:0] {
		OP_SAMPLE = 3'd0,
		OP_START  = 3'd1,
		OP_FINISH = 3'd2,
		OP_ABORT  = 3'd3,
		OP_CLEAR  = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		MODE_NONE = 2'd0,
		MODE_CAL  = 2'd1,
		MODE_DONE = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_READ,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic              start;
		logic [DIV_NW-1:0] num;
		logic [DIV_DW-1:0] den;
	} div_req_t;

endpackage

// ----- rtl/core/kpc_ring_ram.sv -----
// kpc_ring_ram: sample ring storage, one write and one registered read port.
// Depends on kpc_pkg.
module kpc_ring_ram (
	input  logic                           clk,
	input  logic                           we,
	input  logic [kpc_pkg::RING_AW-1:0]     waddr,
	input  logic [kpc_pkg::SAMPLE_BITS-1:0] wdata,
	input  logic [kpc_pkg::RING_AW-1:0]     raddr,
	output logic [kpc_pkg::SAMPLE_BITS-1:0] rdata
);
	import kpc_pkg::*;

	logic [SAMPLE_BITS-1:0] mem [RING_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- rtl/core/kpc_divider.sv -----
// kpc_divider: unsigned restoring divider, one quotient bit per cycle.
// Depends on kpc_pkg.
module kpc_divider (
	input  logic                      clk,
	input  logic                      arst_n,
	input  kpc_pkg::div_req_t         req,
	output logic                      done,
	output logic [kpc_pkg::DIV_NW-1:0] quot
);
	import kpc_pkg::*;

	logic              busy_q;
	logic [DIV_CW-1:0] cnt_q;
	logic [DIV_NW-1:0] num_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_DW-1:0] den_q;
	logic [DIV_DW:0]   trial;
	logic              fits;

	assign trial = {rem_q, num_q[DIV_NW-1]};
	assign fits  = trial >= {1'b0, den_q};
	assign quot  = num_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CW'(DIV_NW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? DIV_DW'(trial - {1'b0, den_q}) : trial[DIV_DW-1:0];
			num_q <= {num_q[DIV_NW-2:0], fits};
		end
	end
endmodule

// ----- rtl/core/key_position_calibrator.sv -----
// Key position calibrator: two-point calibration of a raw key sensor and Q12 position output.
// One request is handled at a time, and a stalled result holds off the next one. A calibrated
// sample runs the divider; a calibrating sample reads a press window (eight ring reads) once
// the ring holds one; a successful-path finish reads the ring fill, then runs the divider for
// the rest average; other commands do neither. The sample ring is a single-port-read RAM.
// Uses kpc_pkg, kpc_ring_ram, kpc_divider.
module key_position_calibrator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [11:0] raw_sample
	input  logic [2:0]  s_tuser,   // [2:0] operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [13:0] position, [14] position_valid, [15] finish_ok, [17:16] mode
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [11:0] cfg_data
);
	import kpc_pkg::*;

	state_t state_q, state_d;

	logic                   down_q;
	logic [11:0]            min_range_q;
	logic [2:0]             op_q;
	logic [SAMPLE_BITS-1:0] raw_q;
	mode_t                  cur_q, prev_q;
	logic [SAMPLE_BITS-1:0] rest_q, press_q, cand_q;
	logic                   rest_known_q, press_known_q, cand_known_q;
	logic [FILL_W-1:0]      fill_q, fill_next, rd_n_q, rd_cnt_q;
	logic [RING_AW-1:0]     head_q;
	logic                   rd_pend_s1;
	logic [SUM_W-1:0]       sum_q;
	logic                   neg_q;
	logic [POS_W-1:0]       pos_q;
	logic                   valid_q, ok_q;

	logic                   mem_we, rd_issue, rd_done, can_div, div_done;
	logic [RING_AW-1:0]     raddr;
	logic [SAMPLE_BITS-1:0] rdata;
	div_req_t               div_req;
	logic [DIV_NW-1:0]      quot;
	logic [SAMPLE_BITS-1:0] raw_mag, span_mag, avg_win, new_rest, gap;
	logic                   raw_below, press_below, cal_done_op;

	assign fill_next = (fill_q == FILL_W'(RING_DEPTH)) ? fill_q : fill_q + 1'b1;
	assign can_div   = rest_known_q && press_known_q && (press_q != rest_q);
	assign raw_below   = raw_q < rest_q;
	assign press_below = press_q < rest_q;
	assign raw_mag   = raw_below ? rest_q - raw_q : raw_q - rest_q;
	assign span_mag  = press_below ? rest_q - press_q : press_q - rest_q;
	assign rd_issue  = (state_q == ST_READ) && (rd_cnt_q < rd_n_q);
	assign rd_done   = (state_q == ST_READ) && (rd_cnt_q == rd_n_q) && !rd_pend_s1;
	assign raddr     = head_q - 1'b1 - rd_cnt_q[RING_AW-1:0];
	assign avg_win   = SAMPLE_BITS'(sum_q / PRESS_WINDOW);
	assign new_rest  = quot[SAMPLE_BITS-1:0];
	assign gap       = (cand_q > new_rest) ? cand_q - new_rest : new_rest - cand_q;
	assign cal_done_op = (op_q == OP_SAMPLE) && (cur_q == MODE_CAL);
	assign s_tready  = (state_q == ST_IDLE);

	kpc_ring_ram u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (head_q),
		.wdata (raw_q),
		.raddr (raddr),
		.rdata (rdata)
	);

	kpc_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quot   (quot)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (s_tvalid) state_d = ST_EXEC;
			ST_EXEC: begin
				state_d = ST_OUT;
				if (op_q == OP_SAMPLE && cur_q == MODE_DONE && can_div) state_d = ST_DIV;
				if (cal_done_op && fill_next >= FILL_W'(PRESS_WINDOW)) state_d = ST_READ;
				if (op_q == OP_FINISH && cur_q == MODE_CAL
				    && fill_q >= FILL_W'(PRESS_WINDOW) && fill_q != '0 && cand_known_q)
					state_d = ST_READ;
			end
			ST_READ: if (rd_done) state_d = (op_q == OP_FINISH) ? ST_DIV : ST_OUT;
			ST_DIV:  if (div_done) state_d = ST_OUT;
			ST_OUT:  if (!m_tvalid || m_tready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		mem_we = (state_q == ST_EXEC) && cal_done_op;
		div_req.start = 1'b0;
		div_req.num   = {raw_mag, 12'd0};
		div_req.den   = span_mag;
		if (state_q == ST_EXEC && op_q == OP_SAMPLE && cur_q == MODE_DONE && can_div)
			div_req.start = 1'b1;
		if (rd_done && op_q == OP_FINISH) begin
			div_req.start = 1'b1;
			div_req.num   = DIV_NW'(sum_q);
			div_req.den   = DIV_DW'(fill_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			down_q        <= 1'b0;
			min_range_q   <= 12'(MIN_RANGE_RST);
			cur_q         <= MODE_NONE;
			prev_q        <= MODE_NONE;
			rest_q        <= '0;
			press_q       <= '0;
			cand_q        <= '0;
			rest_known_q  <= 1'b0;
			press_known_q <= 1'b0;
			cand_known_q  <= 1'b0;
			fill_q        <= '0;
			head_q        <= '0;
			rd_pend_s1    <= 1'b0;
			m_tvalid      <= 1'b0;
		end else begin
			state_q    <= state_d;
			rd_pend_s1 <= rd_issue;
			if (cfg_we) begin
				if (cfg_index == 1'b0) down_q <= cfg_data[0];
				else min_range_q <= cfg_data;
			end
			if (state_q == ST_OUT && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
			else if (m_tready) m_tvalid <= 1'b0;

			if (state_q == ST_EXEC) begin
				case (op_q)
					OP_SAMPLE: if (cur_q == MODE_CAL) begin
						head_q <= head_q + 1'b1;
						fill_q <= fill_next;
					end
					OP_START: begin
						prev_q <= (cur_q != MODE_CAL) ? cur_q
							: ((prev_q == MODE_DONE) ? MODE_DONE : MODE_NONE);
						cur_q  <= MODE_CAL;
						fill_q <= '0;
						head_q <= '0;
						cand_known_q <= 1'b0;
					end
					OP_FINISH, OP_ABORT: if (cur_q == MODE_CAL && state_d == ST_OUT) begin
						prev_q <= MODE_CAL;
						cur_q  <= (prev_q == MODE_DONE) ? MODE_DONE : MODE_NONE;
						fill_q <= '0;
						head_q <= '0;
						cand_known_q <= 1'b0;
					end
					OP_CLEAR: begin
						prev_q <= MODE_NONE;
						cur_q  <= MODE_NONE;
						if (cur_q == MODE_CAL) begin
							fill_q <= '0;
							head_q <= '0;
							cand_known_q <= 1'b0;
						end
					end
					default: ;
				endcase
			end

			if (rd_done && op_q == OP_SAMPLE) begin
				if (!cand_known_q || (down_q ? (avg_win < cand_q) : (avg_win > cand_q))) begin
					cand_q       <= avg_win;
					cand_known_q <= 1'b1;
				end
			end

			if (state_q == ST_DIV && div_done && op_q == OP_FINISH) begin
				prev_q <= MODE_CAL;
				if (gap >= min_range_q) begin
					rest_q        <= new_rest;
					press_q       <= cand_q;
					rest_known_q  <= 1'b1;
					press_known_q <= 1'b1;
					cur_q         <= MODE_DONE;
				end else begin
					cur_q <= (prev_q == MODE_DONE) ? MODE_DONE : MODE_NONE;
				end
				fill_q <= '0;
				head_q <= '0;
				cand_known_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q  <= s_tuser;
			raw_q <= s_tdata[SAMPLE_BITS-1:0];
		end
		if (state_q == ST_EXEC) begin
			pos_q   <= '0;
			valid_q <= 1'b0;
			ok_q    <= 1'b0;
			rd_cnt_q <= '0;
			sum_q    <= '0;
			rd_n_q   <= (op_q == OP_FINISH) ? fill_q : FILL_W'(PRESS_WINDOW);
			neg_q    <= raw_below ^ press_below;
		end
		if (rd_issue) rd_cnt_q <= rd_cnt_q + 1'b1;
		if (rd_pend_s1) sum_q <= sum_q + SUM_W'(rdata);
		if (state_q == ST_DIV && div_done) begin
			if (op_q == OP_FINISH) begin
				ok_q <= (gap >= min_range_q);
			end else begin
				valid_q <= 1'b1;
				if (neg_q) begin
					pos_q <= (quot > DIV_NW'(POS_LOW_MAG)) ? -POS_W'(POS_LOW_MAG)
						: -quot[POS_W-1:0];
				end else begin
					pos_q <= (quot > DIV_NW'(POS_HIGH)) ? POS_W'(POS_HIGH) : quot[POS_W-1:0];
				end
			end
		end
		if (state_q == ST_OUT && (!m_tvalid || m_tready)) begin
			m_tdata <= {6'd0, cur_q, ok_q, valid_q, pos_q};
		end
	end

`ifndef ASSERT_OFF
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> state_q == ST_IDLE) else $error("ready outside idle");
	a_valid_mode: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[14] |-> m_tdata[17:16] == MODE_DONE)
		else $error("valid position while not calibrated");
	a_ok_mode: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[15] |-> m_tdata[17:16] == MODE_DONE && !m_tdata[14])
		else $error("finish ok inconsistent");
	a_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV) else $error("divider result outside divide state");
`endif
endmodule
